### rtl/rkmc_pkg.sv
// rkmc_pkg: shared constants for the remote key and mode controller
// mode flag bit positions, count limits, config register indexes and reset values
// no dependencies

package rkmc_pkg;

  localparam int unsigned StickW = 12;
  localparam int unsigned FlagW  = 5;
  localparam int unsigned UserW  = 5;
  localparam int unsigned CodeW  = 3;
  localparam int unsigned OnCntW = 5;
  localparam int unsigned CalCntW = 4;
  localparam int unsigned CfgIdxW = 2;

  // mode flag bit positions
  localparam int unsigned FlagOnline  = 0;
  localparam int unsigned FlagBind    = 1;
  localparam int unsigned FlagArmed   = 2;
  localparam int unsigned FlagAlt     = 3;
  localparam int unsigned FlagOffline = 4;

  // key count limits
  localparam logic [OnCntW-1:0]  OnCntMax     = OnCntW'(15);
  localparam logic [OnCntW-1:0]  OnCntBack    = OnCntW'(10);
  localparam logic [OnCntW-1:0]  OnLongMin    = OnCntW'(8);
  localparam logic [CalCntW-1:0] CalCntMax    = CalCntW'(10);
  localparam logic [CalCntW-1:0] CalLongMin   = CalCntW'(8);
  localparam logic [1:0]         EventWaitEnd = 2'd3;

  // config register indexes
  localparam logic [CfgIdxW-1:0] CfgBindUsesPitch  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgBindThreshold  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgArmThrottleLim = CfgIdxW'(2);

  // config reset values
  localparam logic [StickW-1:0] BindThresholdRst = StickW'(1600);
  localparam logic [StickW-1:0] ArmThrottleRst   = StickW'(1150);

endpackage

### rtl/remote_key_mode_controller_top.sv
// remote_key_mode_controller_top: poll tick key scanner and mode flag controller
// uses rkmc_pkg for flag positions, count limits and config indexes
// single module: input register, tick logic, result register
//
// Usage: each input item is one poll tick carrying key levels, arm/alt events
// and stick values. The input channel (in_valid_i / in_stall_o) moves one item
// per clock at most; the output channel (out_valid_o / out_stall_i) returns one
// result item per tick with the mode flags after that tick, the led level, the
// released user key code and the one-tick pulses.
// An accepted item is captured in the input register, evaluated against the
// key and mode state and written to the result register once that register
// is free. Throughput: one item per cycle while out_stall_i is low, set by
// the state update loop between the input and result registers.
// Stall: while out_stall_i holds a result, one more item can still be taken
// into the input register; after that in_stall_o rises until the result leaves.
// Reset: all counters, held flags, pending events and mode flags clear, the led
// is unlit, config registers return to pitch off, bind threshold 1600 and arm
// throttle limit 1150. Config writes are taken on any cycle with cfg_we_i high.

module remote_key_mode_controller_top (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        online_pressed_i,
  input  logic        cal_pressed_i,
  input  logic [4:0]  user_pressed_i,
  input  logic        arm_event_i,
  input  logic        alt_event_i,
  input  logic [11:0] stick_pitch_i,
  input  logic [11:0] stick_roll_i,
  input  logic [11:0] stick_throttle_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        online_mode_o,
  output logic        bind_mode_o,
  output logic        armed_o,
  output logic        alt_hold_o,
  output logic        offline_mode_o,
  output logic        led_on_o,
  output logic [2:0]  user_key_code_o,
  output logic        calibrate_pulse_o,
  output logic        bind_confirm_pulse_o,
  output logic        center_sticks_pulse_o,
  output logic        motor_stop_pulse_o
);

  // config registers
  logic                                bind_uses_pitch_q;
  logic [rkmc_pkg::StickW-1:0]         bind_threshold_q;
  logic [rkmc_pkg::StickW-1:0]         arm_throttle_limit_q;

  // input register
  logic                                s1_valid_q, s1_valid_d;
  logic                                s1_online_q, s1_cal_q, s1_arm_q, s1_alt_q;
  logic [rkmc_pkg::UserW-1:0]          s1_user_q;
  logic [rkmc_pkg::StickW-1:0]         s1_pitch_q, s1_roll_q, s1_thr_q;

  // tick state
  logic                                online_held_q, online_held_d;
  logic [rkmc_pkg::OnCntW-1:0]         online_count_q, online_count_d;
  logic                                cal_held_q, cal_held_d;
  logic [rkmc_pkg::CalCntW-1:0]        cal_count_q, cal_count_d;
  logic [rkmc_pkg::UserW-1:0]          user_held_q, user_held_d;
  logic                                arm_pending_q, arm_pending_d;
  logic                                alt_pending_q, alt_pending_d;
  logic [1:0]                          event_wait_q, event_wait_d;
  logic [rkmc_pkg::FlagW-1:0]          mode_flags_q, mode_flags_d;
  logic                                led_state_q, led_state_d;

  // result register
  logic                                out_valid_q, out_valid_d;
  logic [rkmc_pkg::CodeW-1:0]          code_q, code_d;
  logic                                cal_pulse_q, cal_pulse_d;
  logic                                confirm_q, confirm_d;
  logic                                center_q, center_d;
  logic                                mstop_q, mstop_d;

  logic                                out_free;
  logic                                in_take;
  logic                                s1_fire;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_take || (s1_valid_q && !s1_fire);
  assign out_valid_d = s1_fire || (out_valid_q && out_stall_i);

  // tick evaluation
  always_comb begin
    logic [rkmc_pkg::StickW-1:0] first;
    logic                        apply;
    online_held_d  = online_held_q;
    online_count_d = online_count_q;
    cal_held_d     = cal_held_q;
    cal_count_d    = cal_count_q;
    user_held_d    = user_held_q;
    arm_pending_d  = arm_pending_q | s1_arm_q;
    alt_pending_d  = alt_pending_q | s1_alt_q;
    event_wait_d   = event_wait_q;
    mode_flags_d   = mode_flags_q;
    led_state_d    = led_state_q;
    code_d         = '0;
    cal_pulse_d    = 1'b0;
    confirm_d      = 1'b0;
    center_d       = 1'b0;
    mstop_d        = 1'b0;
    first          = bind_uses_pitch_q ? s1_pitch_q : s1_thr_q;
    apply          = 1'b1;

    // online key
    if (s1_online_q) begin
      online_held_d  = 1'b1;
      online_count_d = online_count_q + rkmc_pkg::OnCntW'(1);
      if (online_count_d > rkmc_pkg::OnCntMax) begin
        online_count_d = rkmc_pkg::OnCntBack;
        led_state_d    = 1'b1;
      end
    end else begin
      if (online_held_q && (online_count_q > rkmc_pkg::OnLongMin)) begin
        online_held_d = 1'b0;
        led_state_d   = 1'b0;
        if ((first > bind_threshold_q) && (s1_roll_q > bind_threshold_q)) begin
          mode_flags_d[rkmc_pkg::FlagBind]   = 1'b1;
          mode_flags_d[rkmc_pkg::FlagOnline] = 1'b0;
        end else if (mode_flags_q[rkmc_pkg::FlagBind]) begin
          confirm_d                        = 1'b1;
          mode_flags_d[rkmc_pkg::FlagBind] = 1'b0;
        end else if (mode_flags_q[rkmc_pkg::FlagOnline]) begin
          mode_flags_d[rkmc_pkg::FlagOnline] = 1'b0;
          mstop_d                            = 1'b1;
        end else begin
          mode_flags_d[rkmc_pkg::FlagOnline] = 1'b1;
          center_d                           = 1'b1;
        end
        mode_flags_d[rkmc_pkg::FlagArmed]   = 1'b0;
        mode_flags_d[rkmc_pkg::FlagAlt]     = 1'b0;
        mode_flags_d[rkmc_pkg::FlagOffline] = 1'b0;
      end
      online_count_d = '0;
    end

    if (mode_flags_d[rkmc_pkg::FlagOnline] || mode_flags_d[rkmc_pkg::FlagBind]) begin
      arm_pending_d = 1'b0;
      alt_pending_d = 1'b0;
      cal_held_d    = 1'b0;
      user_held_d   = '0;
    end else begin
      // calibrate key
      if (s1_cal_q) begin
        cal_held_d  = 1'b1;
        cal_count_d = cal_count_q + rkmc_pkg::CalCntW'(1);
        if (cal_count_d > rkmc_pkg::CalCntMax) begin
          cal_count_d = rkmc_pkg::CalCntMax;
          led_state_d = 1'b1;
        end
      end else begin
        if (cal_held_q && (cal_count_q > rkmc_pkg::CalLongMin)) begin
          cal_held_d  = 1'b0;
          cal_pulse_d = 1'b1;
          led_state_d = 1'b0;
        end
        cal_count_d = '0;
      end

      // user keys, highest released key wins
      for (int i = 0; i < rkmc_pkg::UserW; i++) begin
        if (s1_user_q[i]) begin
          user_held_d[i] = 1'b1;
        end else if (user_held_q[i]) begin
          user_held_d[i] = 1'b0;
          if (i < rkmc_pkg::UserW - 1) begin
            code_d = rkmc_pkg::CodeW'(i + 1);
          end else begin
            mode_flags_d[rkmc_pkg::FlagOffline] = !mode_flags_d[rkmc_pkg::FlagOffline];
          end
        end
      end

      // delayed arm and alt-hold events
      if (arm_pending_d || alt_pending_d) begin
        event_wait_d = event_wait_q + 2'd1;
        if (event_wait_d != rkmc_pkg::EventWaitEnd) begin
          apply = 1'b0;
        end else begin
          event_wait_d = '0;
        end
      end
      if (apply) begin
        if (arm_pending_d) begin
          arm_pending_d = 1'b0;
          if (mode_flags_d[rkmc_pkg::FlagArmed]) begin
            mode_flags_d[rkmc_pkg::FlagArmed] = 1'b0;
          end else if (s1_thr_q < arm_throttle_limit_q) begin
            mode_flags_d[rkmc_pkg::FlagArmed] = 1'b1;
          end
        end
        if (alt_pending_d) begin
          alt_pending_d                   = 1'b0;
          mode_flags_d[rkmc_pkg::FlagAlt] = !mode_flags_d[rkmc_pkg::FlagAlt];
        end
      end
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bind_uses_pitch_q    <= 1'b0;
      bind_threshold_q     <= rkmc_pkg::BindThresholdRst;
      arm_throttle_limit_q <= rkmc_pkg::ArmThrottleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rkmc_pkg::CfgBindUsesPitch:  bind_uses_pitch_q    <= cfg_data_i[0];
        rkmc_pkg::CfgBindThreshold:  bind_threshold_q     <= cfg_data_i;
        rkmc_pkg::CfgArmThrottleLim: arm_throttle_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      online_held_q  <= 1'b0;
      online_count_q <= '0;
      cal_held_q     <= 1'b0;
      cal_count_q    <= '0;
      user_held_q    <= '0;
      arm_pending_q  <= 1'b0;
      alt_pending_q  <= 1'b0;
      event_wait_q   <= '0;
      mode_flags_q   <= '0;
      led_state_q    <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        online_held_q  <= online_held_d;
        online_count_q <= online_count_d;
        cal_held_q     <= cal_held_d;
        cal_count_q    <= cal_count_d;
        user_held_q    <= user_held_d;
        arm_pending_q  <= arm_pending_d;
        alt_pending_q  <= alt_pending_d;
        event_wait_q   <= event_wait_d;
        mode_flags_q   <= mode_flags_d;
        led_state_q    <= led_state_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_online_q <= online_pressed_i;
      s1_cal_q    <= cal_pressed_i;
      s1_user_q   <= user_pressed_i;
      s1_arm_q    <= arm_event_i;
      s1_alt_q    <= alt_event_i;
      s1_pitch_q  <= stick_pitch_i;
      s1_roll_q   <= stick_roll_i;
      s1_thr_q    <= stick_throttle_i;
    end
    if (s1_fire) begin
      code_q      <= code_d;
      cal_pulse_q <= cal_pulse_d;
      confirm_q   <= confirm_d;
      center_q    <= center_d;
      mstop_q     <= mstop_d;
    end
  end

  // flags and led are shown from the state, which only moves with a result
  assign out_valid_o           = out_valid_q;
  assign online_mode_o         = mode_flags_q[rkmc_pkg::FlagOnline];
  assign bind_mode_o           = mode_flags_q[rkmc_pkg::FlagBind];
  assign armed_o               = mode_flags_q[rkmc_pkg::FlagArmed];
  assign alt_hold_o            = mode_flags_q[rkmc_pkg::FlagAlt];
  assign offline_mode_o        = mode_flags_q[rkmc_pkg::FlagOffline];
  assign led_on_o              = led_state_q;
  assign user_key_code_o       = code_q;
  assign calibrate_pulse_o     = cal_pulse_q;
  assign bind_confirm_pulse_o  = confirm_q;
  assign center_sticks_pulse_o = center_q;
  assign motor_stop_pulse_o    = mstop_q;

endmodule
